// ===== design/clpe_pkg.sv =====
// Shared constants and codes for the circular list position engine.
package clpe_pkg;

  // Node store size and the widths that follow from it.
  localparam int CAPACITY  = 16;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 8;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  count_t;

endpackage

// ===== design/clpe_free_find.sv =====
// Lowest free slot finder over the slot occupancy map.
module clpe_free_find (
  input  logic [clpe_pkg::CAPACITY-1:0] in_use,
  output clpe_pkg::slot_t               slot
);
  import clpe_pkg::*;

  // Priority encoder: scan from the top so the lowest free slot wins.
  always_comb begin
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== design/circular_list_position_engine_top.sv =====
// Top level of the circular list position engine: control, node memories, result register.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  command, position, value
//   output   out        out_valid / out_stall status, entries, has_value, data_out, last_item
//
// One command is worked at a time; in_stall is high from acceptance until its last
// result is loaded. Insert and delete walk one link at a time: no links for an insert at
// either end or a delete of the head, else position - 2, up to 14 for the tail. A rejected
// command, an insert into an empty list or a delete of the only node goes straight to the
// result; a dump gives one result per node. Reset clears the state, head, tail, count, the
// occupancy map and out_valid. A stalled output holds the result and pauses the dump walk.
module circular_list_position_engine_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [clpe_pkg::CMD_W-1:0]      command,
  input  logic [clpe_pkg::POS_W-1:0]      position,
  input  logic signed [clpe_pkg::DATA_W-1:0] value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clpe_pkg::STATUS_W-1:0]   status,
  output logic [clpe_pkg::ENTRIES_W-1:0]  entries,
  output logic                            has_value,
  output logic signed [clpe_pkg::DATA_W-1:0] data_out,
  output logic                            last_item
);
  import clpe_pkg::*;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_FETCH1   = 3'd2;
  localparam logic [2:0] S_FETCH2   = 3'd3;
  localparam logic [2:0] S_LINK2    = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;
  localparam logic [2:0] S_DUMP_OUT = 3'd6;

  // Node memories.
  logic [DATA_W-1:0] val_mem  [CAPACITY];
  slot_t             link_mem [CAPACITY];

  logic              val_we, val_re;
  slot_t             val_waddr, val_raddr;
  logic [DATA_W-1:0] val_rdata;
  logic              link_we, link_re;
  slot_t             link_waddr, link_raddr, link_wdata, link_rdata;

  // Control and list registers.
  logic [2:0]            state;
  slot_t                 head, tail, cur, sreg;
  count_t                total, remaining;
  logic [CAPACITY-1:0]   in_use;
  slot_t                 steps;
  logic                  pend, op_insert, at_head, at_tail;
  logic [STATUS_W-1:0]   res_status;

  slot_t                 free_slot;
  logic                  accept, out_free;
  logic                  empty, is_full, single;
  logic                  ins_bad, del_bad;
  logic                  pos_first, pos_after, pos_last;
  logic [POS_W:0]        pos_ext, total_ext;
  slot_t                 mid_steps, walk_node;

  clpe_free_find u_free_find (
    .in_use (in_use),
    .slot   (free_slot)
  );

  // Handshake and command decode.
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign pos_ext   = {1'b0, position};
  assign total_ext = (POS_W + 1)'(total);
  assign empty     = (total == '0);
  assign single    = (total == count_t'(1));
  assign is_full   = (total == count_t'(CAPACITY));
  assign pos_first = (position == POS_W'(1));
  assign pos_after = (pos_ext == total_ext + (POS_W + 1)'(1));
  assign pos_last  = (pos_ext == total_ext);
  assign ins_bad   = (position == '0) || (pos_ext > total_ext + (POS_W + 1)'(1));
  assign del_bad   = (position == '0) || (pos_ext > total_ext);
  assign mid_steps = SLOT_W'(position - POS_W'(2));

  // While walking, the link just read is the next node once a read is pending.
  assign walk_node = pend ? link_rdata : cur;

  // Memory port control.
  always_comb begin
    val_we     = 1'b0;
    val_waddr  = free_slot;
    val_re     = 1'b0;
    val_raddr  = head;
    link_we    = 1'b0;
    link_waddr = free_slot;
    link_wdata = free_slot;
    link_re    = 1'b0;
    link_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_INSERT && !ins_bad && !is_full) begin
            val_we = 1'b1;
            if (empty) begin
              link_we = 1'b1;
            end
          end else if (command == CMD_DUMP && !empty) begin
            val_re  = 1'b1;
            link_re = 1'b1;
          end
        end
      end
      S_WALK: begin
        link_re    = 1'b1;
        link_raddr = walk_node;
      end
      S_FETCH1: begin
        if (op_insert) begin
          link_we    = 1'b1;
          link_waddr = sreg;
          link_wdata = link_rdata;
        end else begin
          link_re    = 1'b1;
          link_raddr = link_rdata;
        end
      end
      S_LINK2: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = sreg;
      end
      S_FETCH2: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_rdata;
      end
      S_DUMP_OUT: begin
        if (out_free && remaining != count_t'(1)) begin
          val_re     = 1'b1;
          val_raddr  = link_rdata;
          link_re    = 1'b1;
          link_raddr = link_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Value memory: one write port, one registered read port with enable.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= value;
    end
    if (val_re) begin
      val_rdata <= val_mem[val_raddr];
    end
  end

  // Link memory: one write port, one registered read port with enable.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  // Sequencer and list bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      total  <= '0;
      in_use <= '0;
      pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend      <= 1'b0;
            op_insert <= (command == CMD_INSERT);
            sreg      <= free_slot;
            case (command)
              CMD_INSERT: begin
                at_head <= pos_first;
                at_tail <= pos_after;
                if (ins_bad) begin
                  res_status <= ST_BAD;
                  state      <= S_RESP;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else if (empty) begin
                  head              <= free_slot;
                  tail              <= free_slot;
                  in_use[free_slot] <= 1'b1;
                  total             <= total + count_t'(1);
                  res_status        <= ST_DONE;
                  state             <= S_RESP;
                end else begin
                  // Both ends splice after the tail; a middle slot needs a walk.
                  cur   <= (pos_first || pos_after) ? tail : head;
                  steps <= (pos_first || pos_after) ? '0 : mid_steps;
                  state <= S_WALK;
                end
              end
              CMD_DELETE: begin
                at_head <= pos_first;
                at_tail <= pos_last;
                if (del_bad) begin
                  res_status <= ST_BAD;
                  state      <= S_RESP;
                end else if (single) begin
                  in_use[head] <= 1'b0;
                  head         <= '0;
                  tail         <= '0;
                  total        <= '0;
                  res_status   <= ST_DONE;
                  state        <= S_RESP;
                end else begin
                  cur   <= pos_first ? tail : head;
                  steps <= pos_first ? '0 : mid_steps;
                  state <= S_WALK;
                end
              end
              CMD_DUMP: begin
                if (empty) begin
                  res_status <= ST_BAD;
                  state      <= S_RESP;
                end else begin
                  remaining <= total;
                  state     <= S_DUMP_OUT;
                end
              end
              default: begin
                res_status <= ST_BAD;
                state      <= S_RESP;
              end
            endcase
          end
        end
        // Follow one link per cycle until the predecessor node is reached.
        S_WALK: begin
          cur <= walk_node;
          if (steps == '0) begin
            pend  <= 1'b0;
            state <= S_FETCH1;
          end else begin
            steps <= steps - SLOT_W'(1);
            pend  <= 1'b1;
          end
        end
        // Link of the predecessor is now read.
        S_FETCH1: begin
          if (op_insert) begin
            state <= S_LINK2;
          end else begin
            sreg  <= link_rdata;
            state <= S_FETCH2;
          end
        end
        S_LINK2: begin
          if (at_head) begin
            head <= sreg;
          end
          if (at_tail) begin
            tail <= sreg;
          end
          in_use[sreg] <= 1'b1;
          total        <= total + count_t'(1);
          res_status   <= ST_DONE;
          state        <= S_RESP;
        end
        S_FETCH2: begin
          if (at_head) begin
            head <= link_rdata;
          end
          if (at_tail) begin
            tail <= cur;
          end
          in_use[sreg] <= 1'b0;
          total        <= total - count_t'(1);
          res_status   <= ST_DONE;
          state        <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            remaining <= remaining - count_t'(1);
            if (remaining == count_t'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: loaded when free or when the held result transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == S_RESP || state == S_DUMP_OUT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == S_RESP) begin
      status    <= res_status;
      entries   <= ENTRIES_W'(total);
      has_value <= 1'b0;
      data_out  <= '0;
      last_item <= 1'b1;
    end else if (out_free && state == S_DUMP_OUT) begin
      status    <= ST_DONE;
      entries   <= ENTRIES_W'(total);
      has_value <= 1'b1;
      data_out  <= val_rdata;
      last_item <= (remaining == count_t'(1));
    end
  end

endmodule

// ===== tb/tb_circular_list_position_engine_top.sv =====
// Self-checking testbench for the circular list position engine, with its own list predictor.
module tb_circular_list_position_engine_top;
  import clpe_pkg::*;

  // The one command code that the package leaves unnamed.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_COMMANDS = 96;

  // Receiver stall styles, each held for a random run of cycles.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_style_t;

  // One expected or observed result transfer.
  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [ENTRIES_W-1:0] entries;
    logic                 has_value;
    logic [DATA_W-1:0]    data_out;
    logic                 last_item;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = CMD_INSERT;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ENTRIES_W-1:0] entries;
  logic has_value;
  logic signed [DATA_W-1:0] data_out;
  logic last_item;

  // Predictor state: node values in list order, head first.
  logic [DATA_W-1:0] list_contents[$];
  list_result_t pending_results[$];

  int error_count = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int dumps_sent = 0;
  int times_full = 0;
  int times_emptied = 0;
  int burst_left = 0;

  circular_list_position_engine_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .entries(entries), .has_value(has_value),
    .data_out(data_out), .last_item(last_item)
  );

  always #6 clk = ~clk;

  // Predict the results of one command and update the list image.
  function automatic void predict_list_command(input logic [CMD_W-1:0] cmd,
                                               input logic [POS_W-1:0] pos,
                                               input logic [DATA_W-1:0] val);
    list_result_t r;
    int count;
    int p;
    count = list_contents.size();
    p = int'(pos);
    r.status = ST_BAD;
    r.has_value = 1'b0;
    r.data_out = '0;
    r.last_item = 1'b1;
    if (cmd == CMD_INSERT) begin
      if (p < 1 || p > count + 1) begin
        r.status = ST_BAD;
      end else if (count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        list_contents.insert(p - 1, val);
        r.status = ST_DONE;
        if (list_contents.size() == CAPACITY) times_full++;
      end
    end else if (cmd == CMD_DELETE) begin
      if (p >= 1 && p <= count) begin
        list_contents.delete(p - 1);
        r.status = ST_DONE;
        if (list_contents.size() == 0) times_emptied++;
      end
    end else if (cmd == CMD_DUMP && count > 0) begin
      for (int i = 0; i < count; i++) begin
        r.status = ST_DONE;
        r.entries = ENTRIES_W'(count);
        r.has_value = 1'b1;
        r.data_out = list_contents[i];
        r.last_item = (i == count - 1);
        pending_results.push_back(r);
      end
      return;
    end
    r.entries = ENTRIES_W'(list_contents.size());
    pending_results.push_back(r);
  endfunction

  // Send one command: handle the burst gap, then hold the transfer until accepted.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    end
    predict_list_command(cmd, pos, val);
    if (cmd == CMD_DUMP) dumps_sent++;
    commands_sent++;
    in_valid <= 1'b1;
    command <= cmd;
    position <= pos;
    value <= val;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Drop valid and wait until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Commands against an empty list, and the unused command code.
  task automatic test_empty_list();
    send_command(CMD_DUMP, 8'd1, $urandom);
    send_command(CMD_DELETE, 8'd1, $urandom);
    send_command(CMD_INSERT, 8'd0, $urandom);
    send_command(CMD_UNUSED, 8'd1, $urandom);
    drain_results();
  endtask

  // Fill to capacity through head, tail and middle inserts, then hit the full limit and dump.
  task automatic test_fill_to_capacity();
    int n;
    send_command(CMD_INSERT, 8'd1, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 8'd2, 32'h8000_0000);
    send_command(CMD_INSERT, 8'd1, 32'h0000_0000);
    send_command(CMD_INSERT, 8'd2, 32'hFFFF_FFFF);
    for (int k = 0; k < CAPACITY - 4; k++) begin
      n = list_contents.size();
      case (k % 3)
        0: send_command(CMD_INSERT, 8'd1, $urandom);
        1: send_command(CMD_INSERT, POS_W'(n + 1), $urandom);
        default: send_command(CMD_INSERT, POS_W'(n / 2 + 1), $urandom);
      endcase
    end
    // A valid position on a full list is refused; a bad one is reported as bad first.
    send_command(CMD_INSERT, POS_W'(CAPACITY + 1), $urandom);
    send_command(CMD_INSERT, 8'd255, $urandom);
    send_command(CMD_DUMP, 8'd0, $urandom);
    drain_results();
  endtask

  // Delete beyond the end, at the head, at the tail and in the middle.
  task automatic test_delete_positions();
    send_command(CMD_DELETE, POS_W'(CAPACITY + 1), $urandom);
    send_command(CMD_DELETE, 8'd1, $urandom);
    send_command(CMD_DELETE, POS_W'(list_contents.size()), $urandom);
    send_command(CMD_DELETE, 8'd7, $urandom);
    drain_results();
  endtask

  // Mostly well-formed inserts and deletes that swing the list between full and empty.
  task automatic test_random_commands();
    bit growing;
    int n;
    int roll;
    growing = 1'b0;
    for (int k = 0; k < RANDOM_COMMANDS; k++) begin
      n = list_contents.size();
      roll = $urandom_range(0, 99);
      if (n == CAPACITY && $urandom_range(0, 1) == 0) growing = 1'b0;
      if (n == 0) growing = 1'b1;
      if (roll < 8) begin
        send_command(CMD_DUMP, POS_W'($urandom), $urandom);
      end else if (roll < 11) begin
        send_command(CMD_UNUSED, POS_W'($urandom), $urandom);
      end else if (roll < 14) begin
        send_command(CMD_INSERT, ($urandom_range(0, 1) == 0) ? 8'd0 :
                     POS_W'($urandom_range(n + 2, 255)), $urandom);
      end else if (roll < 17) begin
        send_command(CMD_DELETE, ($urandom_range(0, 1) == 0) ? 8'd0 :
                     POS_W'($urandom_range(n + 1, 255)), $urandom);
      end else if ((growing && roll < 80) || (!growing && roll >= 80) || n == 0) begin
        send_command(CMD_INSERT, POS_W'($urandom_range(1, n + 1)), $urandom);
      end else begin
        send_command(CMD_DELETE, POS_W'($urandom_range(1, n)), $urandom);
      end
    end
    drain_results();
  endtask

  // Receiver stall pattern, switching style after each random run.
  stall_style_t stall_style = STALL_NONE;
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_run = $urandom_range(10, 60);
    end else begin
      stall_run--;
    end
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_run % 3 == 0);
    endcase
  end

  // Report one field that differs from its prediction.
  task automatic report_field(input string field, input logic [DATA_W-1:0] expected_val,
                              input logic [DATA_W-1:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
               expected_val, actual_val);
      error_count++;
    end
  endtask

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d entries %0d",
                 $time, status, entries);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("status", DATA_W'(want.status), DATA_W'(status));
        report_field("entries", DATA_W'(want.entries), DATA_W'(entries));
        report_field("has_value", DATA_W'(want.has_value), DATA_W'(has_value));
        report_field("data_out", want.data_out, data_out);
        report_field("last_item", DATA_W'(want.last_item), DATA_W'(last_item));
        results_checked++;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_fill_to_capacity();
    test_delete_positions();
    test_random_commands();
    repeat (40) @(posedge clk);
    $display("Sent %0d commands (%0d dumps) and checked %0d results.", commands_sent,
             dumps_sent, results_checked);
    $display("The list reached capacity %0d times and was emptied %0d times.", times_full,
             times_emptied);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #6000000;
    $display("%0t: run limit reached with %0d results outstanding", $time,
             pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/clpe_pkg.sv
design/clpe_free_find.sv
design/circular_list_position_engine_top.sv
tb/tb_circular_list_position_engine_top.sv
